/* sv/mctb_pkg.sv */
// Shared widths, defaults and command codes for the countdown timer bank.
`timescale 1ns / 1ps

package mctb_pkg;

  localparam int KIND_W         = 3;
  localparam int INDEX_W        = 5;
  localparam int WORD_W         = 32;
  localparam int NUM_TIMERS_DEF = 32;

  localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELOAD   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SET_RUN  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STOP     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_STOP_ALL = 3'd6;
  localparam logic [KIND_W-1:0] KIND_POLL     = 3'd7;

endpackage

/* sv/mctb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module mctb_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/multi_channel_countdown_timer_bank.sv */
// Top level of the countdown timer bank: command sequencer around count and base RAMs.
//
//   channel   direction  handshake             fields
//   command   in         start & !busy         kind, timer_index, time_value, base_value,
//                                              run_flag
//   result    out        done (one-cycle)      count_value, pending_events
//
// Steps from accept to done: tick reads the count RAM once per timer, pipelined with the
// write-back of the previous one; start and reload read the base, multiply, then write;
// read waits on the count RAM read; set run, stop, stop all and poll finish from idle.
// Reset clears the run, expiry and entry-valid flops at once; an entry not yet written
// reads as zero, so there is no clearing pass. The receiver cannot stall: done is shown
// for one cycle and a new word may be accepted in that same cycle.
`timescale 1ns / 1ps

module multi_channel_countdown_timer_bank #(
  parameter int NUM_TIMERS = mctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mctb_pkg::KIND_W-1:0]   kind,
  input  logic [mctb_pkg::INDEX_W-1:0]  timer_index,
  input  logic [mctb_pkg::WORD_W-1:0]   time_value,
  input  logic [mctb_pkg::WORD_W-1:0]   base_value,
  input  logic                          run_flag,
  output logic                          done,
  output logic [mctb_pkg::WORD_W-1:0]   count_value,
  output logic [mctb_pkg::WORD_W-1:0]   pending_events
);

  import mctb_pkg::*;

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [AW:0]   SWEEP_END = (AW + 1)'(NUM_TIMERS);
  localparam logic [AW-1:0] LAST_IDX  = AW'(NUM_TIMERS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TICK  = 5'b00010,
    S_MUL   = 5'b00100,
    S_WRITE = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t state;

  // latched command word
  logic [KIND_W-1:0] cmd_kind;
  logic [AW-1:0]     tidx;
  logic [WORD_W-1:0] tval;
  logic [WORD_W-1:0] bval;
  logic [WORD_W-1:0] prod;

  // per-timer flops
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] expired;
  logic [NUM_TIMERS-1:0] cnt_valid;
  logic [NUM_TIMERS-1:0] base_valid;

  // tick sweep
  logic [AW:0]   issue_idx;
  logic          p_valid;
  logic [AW-1:0] p_idx;

  logic              accept;
  logic              in_ok;
  logic [AW-1:0]     in_addr;
  logic [WORD_W-1:0] mask_now;

  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [WORD_W-1:0] cnt_wdata;
  logic [AW-1:0]     cnt_raddr;
  logic [WORD_W-1:0] cnt_rdata;
  logic              base_we;
  logic [WORD_W-1:0] base_rdata;

  logic [WORD_W-1:0] sweep_cnt;
  logic [WORD_W-1:0] mul_b;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign in_ok   = (32'(timer_index) < NUM_TIMERS);
  assign in_addr = AW'(timer_index);

  // expiry mask as seen on poll: only the low 32 timers report
  for (genvar i = 0; i < WORD_W; i++) begin : g_mask
    if (i < NUM_TIMERS) begin : g_on
      assign mask_now[i] = expired[i];
    end else begin : g_off
      assign mask_now[i] = 1'b0;
    end
  end

  assign sweep_cnt = cnt_valid[p_idx] ? cnt_rdata : '0;
  assign mul_b     = (cmd_kind == KIND_START) ? bval
                   : (base_valid[tidx] ? base_rdata : '0);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = tidx;
    cnt_wdata = prod;
    base_we   = 1'b0;
    cnt_raddr = in_addr;
    unique case (state)
      S_TICK: begin
        cnt_raddr = issue_idx[AW-1:0];
        cnt_waddr = p_idx;
        cnt_wdata = sweep_cnt - WORD_W'(1);
        cnt_we    = p_valid && running[p_idx] && (sweep_cnt != '0);
      end
      S_WRITE: begin
        cnt_we  = 1'b1;
        base_we = (cmd_kind == KIND_START);
      end
      default: begin
      end
    endcase
  end

  mctb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_TIMERS)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  mctb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_TIMERS)
  ) u_base_ram (
    .clk  (clk),
    .we   (base_we),
    .waddr(tidx),
    .wdata(bval),
    .raddr(in_addr),
    .rdata(base_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      running    <= '0;
      expired    <= '0;
      cnt_valid  <= '0;
      base_valid <= '0;
      p_valid    <= 1'b0;
      issue_idx  <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_kind       <= kind;
            tidx           <= in_addr;
            tval           <= time_value;
            bval           <= base_value;
            count_value    <= '0;
            pending_events <= '0;
            issue_idx      <= '0;
            p_valid        <= 1'b0;
            unique case (kind)
              KIND_TICK: begin
                state <= S_TICK;
              end
              KIND_START, KIND_RELOAD: begin
                if (in_ok) begin
                  state <= S_MUL;
                end else begin
                  done <= 1'b1;
                end
              end
              KIND_READ: begin
                if (in_ok) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              KIND_SET_RUN: begin
                if (in_ok) begin
                  running[in_addr] <= run_flag;
                end
                done <= 1'b1;
              end
              KIND_STOP: begin
                if (in_ok) begin
                  cnt_valid[in_addr] <= 1'b0;
                  running[in_addr]   <= 1'b0;
                  expired[in_addr]   <= 1'b0;
                end
                done <= 1'b1;
              end
              KIND_STOP_ALL: begin
                cnt_valid <= '0;
                running   <= '0;
                expired   <= '0;
                done      <= 1'b1;
              end
              KIND_POLL: begin
                pending_events <= mask_now;
                expired        <= '0;
                done           <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_TICK: begin
          // read timer issue_idx while writing back timer p_idx
          if (issue_idx != SWEEP_END) begin
            issue_idx <= issue_idx + (AW + 1)'(1);
            p_valid   <= 1'b1;
            p_idx     <= issue_idx[AW-1:0];
          end else begin
            p_valid <= 1'b0;
          end
          if (p_valid && running[p_idx] && (sweep_cnt == WORD_W'(1))) begin
            expired[p_idx] <= 1'b1;
          end
          if (p_valid && (p_idx == LAST_IDX)) begin
            p_valid <= 1'b0;
            done    <= 1'b1;
            state   <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= WORD_W'(tval * mul_b);
          state <= S_WRITE;
        end
        S_WRITE: begin
          cnt_valid[tidx] <= 1'b1;
          running[tidx]   <= 1'b1;
          if (cmd_kind == KIND_START) begin
            base_valid[tidx] <= 1'b1;
            expired[tidx]    <= 1'b0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_READ: begin
          count_value <= cnt_valid[tidx] ? cnt_rdata : '0;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking bench for the countdown timer bank: command driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb;
  import mctb_pkg::*;

  localparam int NT           = NUM_TIMERS_DEF;
  localparam int TARGET_WORDS = 1850;
  localparam int TAIL_CYCLES  = NT + 8;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  tval;
    logic [WORD_W-1:0]  bval;
    logic               rflag;
    int                 gap;
    bit                 drain;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] count;
    logic [WORD_W-1:0] mask;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic [KIND_W-1:0]  kind = KIND_TICK;
  logic [INDEX_W-1:0] timer_index = '0;
  logic [WORD_W-1:0]  time_value = '0;
  logic [WORD_W-1:0]  base_value = '0;
  logic               run_flag = 1'b0;
  logic [WORD_W-1:0]  count_value;
  logic [WORD_W-1:0]  pending_events;

  // predicted bank contents
  logic [WORD_W-1:0] tmr_count [NT];
  logic [WORD_W-1:0] tmr_base  [NT];
  bit                tmr_run     [NT];
  bit                tmr_expired [NT];

  cmd_t    cmd_backlog [$];
  result_t owed_results [$];

  int n_issued = 0;
  int n_accepted = 0;
  int idle_left = 0;
  int errors = 0;
  int results_checked = 0;
  int expiries_seen = 0;
  int kind_seen [8];
  bit quiet_mode = 1'b0;
  bit drain_next = 1'b0;

  always #6 clk = ~clk;

  multi_channel_countdown_timer_bank #(.NUM_TIMERS(NT)) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .timer_index    (timer_index),
    .time_value     (time_value),
    .base_value     (base_value),
    .run_flag       (run_flag),
    .done           (done),
    .count_value    (count_value),
    .pending_events (pending_events)
  );

  task automatic advance_timers(input cmd_t w, output result_t r);
    int t;
    int i;
    logic [WORD_W-1:0] prod;
    r = '0;
    t = int'(w.idx);
    case (w.kind)
      KIND_TICK: begin
        for (i = 0; i < NT; i++) begin
          if (tmr_run[i] && tmr_count[i] != '0) begin
            tmr_count[i] = tmr_count[i] - 1'b1;
            if (tmr_count[i] == '0) tmr_expired[i] = 1'b1;
          end
        end
      end
      KIND_START: begin
        if (t < NT) begin
          prod = w.tval * w.bval;   // low 32 bits of the product
          tmr_count[t] = prod;
          tmr_base[t] = w.bval;
          tmr_run[t] = 1'b1;
          tmr_expired[t] = 1'b0;
        end
      end
      KIND_RELOAD: begin
        if (t < NT) begin
          prod = tmr_base[t] * w.tval;
          tmr_count[t] = prod;
          tmr_run[t] = 1'b1;
        end
      end
      KIND_READ: begin
        if (t < NT) r.count = tmr_count[t];
      end
      KIND_SET_RUN: begin
        if (t < NT) tmr_run[t] = w.rflag;
      end
      KIND_STOP: begin
        if (t < NT) begin
          tmr_count[t] = '0;
          tmr_run[t] = 1'b0;
          tmr_expired[t] = 1'b0;
        end
      end
      KIND_STOP_ALL: begin
        for (i = 0; i < NT; i++) begin
          tmr_count[i] = '0;
          tmr_run[i] = 1'b0;
          tmr_expired[i] = 1'b0;
        end
      end
      KIND_POLL: begin
        for (i = 0; i < NT; i++) begin
          if (tmr_expired[i] && i < WORD_W) r.mask[i] = 1'b1;
          tmr_expired[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // result check first (it belongs to an older word), then take the new word
  always @(posedge clk) begin
    cmd_t w;
    result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < NT; i++) begin
        tmr_count[i] = '0;
        tmr_base[i] = '0;
        tmr_run[i] = 1'b0;
        tmr_expired[i] = 1'b0;
      end
    end else begin
      if (done) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual count=%h events=%h",
                   $time, count_value, pending_events);
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          expiries_seen += $countones(pending_events);
          if (count_value !== want.count) begin
            errors++;
            $display("%0t: count_value expected %h actual %h", $time, want.count, count_value);
          end
          if (pending_events !== want.mask) begin
            errors++;
            $display("%0t: pending_events expected %h actual %h",
                     $time, want.mask, pending_events);
          end
        end
      end
      if (start && !busy) begin
        w = '0;
        w.kind = kind;
        w.idx = timer_index;
        w.tval = time_value;
        w.bval = base_value;
        w.rflag = run_flag;
        advance_timers(w, want);
        owed_results.push_back(want);
        kind_seen[kind]++;
        n_accepted++;
      end
    end
  end

  always @(negedge clk) begin
    cmd_t w;
    if (rst) begin
      start <= 1'b0;
    end else if (n_issued != n_accepted) begin
      // word still waiting for acceptance: hold it
    end else if (idle_left > 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (cmd_backlog.size() != 0 &&
                 !(cmd_backlog[0].drain && owed_results.size() != 0)) begin
      w = cmd_backlog.pop_front();
      kind <= w.kind;
      timer_index <= w.idx;
      time_value <= w.tval;
      base_value <= w.bval;
      run_flag <= w.rflag;
      start <= 1'b1;
      idle_left = w.gap;
      n_issued++;
    end else begin
      start <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_word(input logic [KIND_W-1:0] k, input int idx,
                            input logic [WORD_W-1:0] tv, input logic [WORD_W-1:0] bv,
                            input logic rf);
    cmd_t w;
    w.kind = k;
    w.idx = idx[INDEX_W-1:0];
    w.tval = tv;
    w.bval = bv;
    w.rflag = rf;
    w.gap = pick_gap();
    w.drain = drain_next;
    drain_next = 1'b0;
    cmd_backlog.push_back(w);
  endtask

  function automatic logic rnd_bit();
    return logic'($urandom_range(1));
  endfunction

  initial begin
    int n;
    int sel;
    int idx;

    // directed opening
    queue_word(KIND_POLL, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_READ, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_START, 0, 32'd3, 32'd1, 1'b0);
    queue_word(KIND_START, NT - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // product wraps to 1
    queue_word(KIND_START, 5, 32'h0001_0000, 32'h0001_0000, 1'b0);      // low bits all zero
    queue_word(KIND_START, 6, 32'd0, 32'd7, 1'b1);
    queue_word(KIND_START, 7, 32'd2, 32'd2, 1'b0);
    queue_word(KIND_SET_RUN, 7, $urandom(), $urandom(), 1'b0);          // paused holds
    queue_word(KIND_TICK, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_TICK, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_TICK, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_READ, 0, $urandom(), $urandom(), 1'b1);
    queue_word(KIND_READ, 7, $urandom(), $urandom(), 1'b0);
    queue_word(KIND_READ, NT - 1, $urandom(), $urandom(), 1'b1);
    queue_word(KIND_RELOAD, 7, 32'd1, 32'hDEAD_BEEF, 1'b0);
    queue_word(KIND_POLL, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_TICK, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_TICK, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_RELOAD, 7, 32'd0, $urandom(), 1'b1);               // expiry bit survives
    queue_word(KIND_POLL, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_START, 3, 32'd5, 32'd1, 1'b0);
    queue_word(KIND_STOP, 3, $urandom(), $urandom(), 1'b1);
    queue_word(KIND_RELOAD, 3, 32'd2, $urandom(), 1'b0);               // base kept across stop
    queue_word(KIND_READ, 3, $urandom(), $urandom(), 1'b0);
    queue_word(KIND_STOP_ALL, 0, $urandom(), $urandom(), rnd_bit());
    queue_word(KIND_READ, 3, $urandom(), $urandom(), 1'b1);
    drain_next = 1'b1;

    // random episodes: mostly arm-and-run-down sequences, some raw noise
    while (cmd_backlog.size() < TARGET_WORDS) begin
      quiet_mode = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) drain_next = 1'b1;
      if ($urandom_range(9) < 7) begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          idx = $urandom_range(NT - 1);
          if ($urandom_range(7) == 0)
            queue_word(KIND_START, idx, $urandom(), $urandom(), rnd_bit());
          else
            queue_word(KIND_START, idx, $urandom_range(0, 6), $urandom_range(1, 4), rnd_bit());
        end
        n = $urandom_range(5, 30);
        repeat (n) begin
          sel = $urandom_range(99);
          idx = $urandom_range(NT - 1);
          if (sel < 45)
            queue_word(KIND_TICK, idx, $urandom(), $urandom(), rnd_bit());
          else if (sel < 60)
            queue_word(KIND_READ, idx, $urandom(), $urandom(), rnd_bit());
          else if (sel < 70)
            queue_word(KIND_POLL, idx, $urandom(), $urandom(), rnd_bit());
          else if (sel < 80)
            queue_word(KIND_SET_RUN, idx, $urandom(), $urandom(), rnd_bit());
          else if (sel < 88)
            queue_word(KIND_RELOAD, idx, $urandom_range(0, 4), $urandom(), rnd_bit());
          else if (sel < 95)
            queue_word(KIND_STOP, idx, $urandom(), $urandom(), rnd_bit());
          else if (sel < 97)
            queue_word(KIND_STOP_ALL, idx, $urandom(), $urandom(), rnd_bit());
          else
            queue_word(KIND_START, idx, $urandom_range(0, 6), $urandom_range(1, 4), rnd_bit());
        end
      end else begin
        n = $urandom_range(1, 8);
        repeat (n)
          queue_word(KIND_W'($urandom_range(7)), $urandom_range(NT - 1),
                     $urandom(), $urandom(), rnd_bit());
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || n_issued != n_accepted || owed_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d words (tick %0d, start %0d, reload %0d, read %0d, set run %0d,",
             n_accepted, kind_seen[KIND_TICK], kind_seen[KIND_START],
             kind_seen[KIND_RELOAD], kind_seen[KIND_READ], kind_seen[KIND_SET_RUN]);
    $display("  stop %0d, stop all %0d, poll %0d); %0d results checked, %0d expiries polled",
             kind_seen[KIND_STOP], kind_seen[KIND_STOP_ALL], kind_seen[KIND_POLL],
             results_checked, expiries_seen);
    if (errors == 0 && owed_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(64'd12 * 64'd800_000);
    $display("%0t: timeout with %0d words queued, %0d results owed",
             $time, cmd_backlog.size(), owed_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
